FILE: rtl/gcd_of_up_to_four_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the GCD block
// Shared concurrent assertion forms, clocked on aclk and off during reset.
// ----------------------------------------------------------------------------
`ifndef GCD_OF_UP_TO_FOUR_MACROS_SVH
`define GCD_OF_UP_TO_FOUR_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define GCD4_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// A signal holds its value in the cycle after the condition was seen.
`define GCD4_ASSERT_HOLD(lbl, cond, sig, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

FILE: rtl/gcd4_pkg.sv
// ----------------------------------------------------------------------------
// GCD package
// Field widths and stream packing constants shared by the GCD block.
// ----------------------------------------------------------------------------
package gcd4_pkg;

    localparam int FIELD_W     = 32;
    localparam int COUNT_W     = 3;
    localparam int MIN_OPERANDS = 2;
    localparam int S_TDATA_W   = 136;
    localparam int M_TDATA_W   = 32;

    // Bit positions of the input fields within s_tdata.
    localparam int COUNT_LSB = 0;
    localparam int A_LSB     = COUNT_LSB + COUNT_W;
    localparam int B_LSB     = A_LSB + FIELD_W;
    localparam int C_LSB     = B_LSB + FIELD_W;
    localparam int D_LSB     = C_LSB + FIELD_W;

endpackage

FILE: rtl/gcd4_core.sv
// ----------------------------------------------------------------------------
// GCD iterative core
// Binary GCD of two operands, one shift or subtract step per cycle.
// ----------------------------------------------------------------------------
module gcd4_core import gcd4_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] x,
    input  logic [WIDTH-1:0] y,
    output logic             busy,
    output logic [WIDTH-1:0] result
);

    localparam int K_W = $clog2(WIDTH + 1);

    logic             busy_reg, busy_next;
    logic [WIDTH-1:0] a_reg, a_next, b_reg, b_next;
    logic [K_W-1:0]   k_reg, k_next;

    // When both operands are zero they are already equal, giving zero.
    always_comb begin
        busy_next = busy_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        k_next    = k_reg;
        if (start) begin
            busy_next = 1'b1;
            a_next    = x;
            b_next    = y;
            k_next    = '0;
        end else if (busy_reg) begin
            priority if (a_reg == b_reg) begin
                busy_next = 1'b0;
            end else if (!a_reg[0] && !b_reg[0]) begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end else if (!a_reg[0]) begin
                a_next = a_reg >> 1;
            end else if (!b_reg[0]) begin
                b_next = b_reg >> 1;
            end else if (a_reg > b_reg) begin
                a_next = (a_reg - b_reg) >> 1;
            end else begin
                b_next = (b_reg - a_reg) >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
    end

    assign busy   = busy_reg;
    assign result = a_reg << k_reg;

endmodule

FILE: rtl/gcd_of_up_to_four.sv
// The time per beat is set by the binary GCD steps of the two lane cores,
// followed by the merging core for three or four operands.
// Throughput: one beat in flight at a time; a new input beat is taken once
// the previous result beat has been taken. Errors and zero operands bypass
// the cores. Reset (aresetn low, synchronous) empties the block.
// ----------------------------------------------------------------------------
// GCD of up to four operands
// Two lanes find gcd(a,b) and gcd(c,d) side by side; for three or four
// operands a merging core then combines both lane results into the divisor.
// ----------------------------------------------------------------------------
module gcd_of_up_to_four import gcd4_pkg::*; #(
    parameter int DATA_WIDTH   = 32,
    parameter int MAX_OPERANDS = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // operand_count[2:0], value_a[34:3], value_b[66:35], value_c[98:67],
    // value_d[130:99], zero padding above.
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // divisor[31:0].
    output logic [M_TDATA_W-1:0] m_tdata,
    // count_error[0].
    output logic                 m_tuser
);

    // Operands are masked to the narrower of the parameter and the field.
    localparam int OPW = (DATA_WIDTH < FIELD_W) ? DATA_WIDTH : FIELD_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LANES = 4'b0010,
        ST_MERGE = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0] count_w;
    logic [FIELD_W-1:0] a_f, b_f, c_f, d_f;
    logic [OPW-1:0]     a_w, b_w, c_w, d_w;

    assign count_w = s_tdata[COUNT_LSB +: COUNT_W];
    assign a_f     = s_tdata[A_LSB +: FIELD_W];
    assign b_f     = s_tdata[B_LSB +: FIELD_W];
    assign c_f     = s_tdata[C_LSB +: FIELD_W];
    assign d_f     = s_tdata[D_LSB +: FIELD_W];
    assign a_w     = a_f[OPW-1:0];
    assign b_w     = b_f[OPW-1:0];
    assign c_w     = c_f[OPW-1:0];
    assign d_w     = d_f[OPW-1:0];

    logic s_accept;
    logic count_bad, any_zero;

    assign s_accept  = s_tvalid && s_tready;
    assign count_bad = (count_w < COUNT_W'(MIN_OPERANDS)) ||
                       (count_w > COUNT_W'(MAX_OPERANDS));
    assign any_zero  = (a_w == '0) || (b_w == '0) ||
                       ((count_w >= COUNT_W'(3)) && (c_w == '0)) ||
                       ((count_w >= COUNT_W'(4)) && (d_w == '0));

    // Lane one sees (c,c) for three operands so that it returns c itself.
    logic [OPW-1:0] lane1_y;
    assign lane1_y = (count_w == COUNT_W'(4)) ? d_w : c_w;

    logic           lanes_start, merge_start;
    logic           lane0_busy, lane1_busy, merge_busy;
    logic [OPW-1:0] lane0_res, lane1_res, merge_res;

    assign lanes_start = s_accept && !count_bad && !any_zero;

    gcd4_core #(.WIDTH(OPW)) u_lane0 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lanes_start),
        .x       (a_w),
        .y       (b_w),
        .busy    (lane0_busy),
        .result  (lane0_res)
    );

    gcd4_core #(.WIDTH(OPW)) u_lane1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lanes_start),
        .x       (c_w),
        .y       (lane1_y),
        .busy    (lane1_busy),
        .result  (lane1_res)
    );

    gcd4_core #(.WIDTH(OPW)) u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (merge_start),
        .x       (lane0_res),
        .y       (lane1_res),
        .busy    (merge_busy),
        .result  (merge_res)
    );

    logic [COUNT_W-1:0] count_reg, count_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [FIELD_W-1:0] divisor_reg, divisor_next;
    logic               error_reg, error_next;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg;
        divisor_next  = divisor_reg;
        error_next    = error_reg;
        merge_start   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    count_next = count_w;
                    if (count_bad || any_zero) begin
                        // Bad count or a zero operand: the divisor is zero.
                        divisor_next  = '0;
                        error_next    = count_bad;
                        m_tvalid_next = 1'b1;
                        state_next    = ST_OUT;
                    end else begin
                        error_next = 1'b0;
                        state_next = ST_LANES;
                    end
                end
            end
            ST_LANES: begin
                if (!lane0_busy && !lane1_busy) begin
                    if (count_reg == COUNT_W'(MIN_OPERANDS)) begin
                        divisor_next  = FIELD_W'(lane0_res);
                        m_tvalid_next = 1'b1;
                        state_next    = ST_OUT;
                    end else begin
                        merge_start = 1'b1;
                        state_next  = ST_MERGE;
                    end
                end
            end
            ST_MERGE: begin
                if (!merge_busy) begin
                    divisor_next  = FIELD_W'(merge_res);
                    m_tvalid_next = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next    = ST_IDLE;
                m_tvalid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        count_reg   <= count_next;
        divisor_reg <= divisor_next;
        error_reg   <= error_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = divisor_reg;
    assign m_tuser  = error_reg;

endmodule

FILE: rtl/gcd4_checker.sv
// ----------------------------------------------------------------------------
// GCD port checker
// Watches the stream ports of the GCD block over time.
// ----------------------------------------------------------------------------
`include "gcd_of_up_to_four_macros.svh"

module gcd4_checker import gcd4_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

`GCD4_ASSERT_HOLD(a_hold_data, m_tvalid && !m_tready, m_tdata, "result beat changed while stalled")
`GCD4_ASSERT_HOLD(a_hold_input, s_tvalid && !s_tready, s_tdata, "input beat changed while waiting")
`GCD4_ASSERT(a_one_in_flight, m_tvalid, !s_tready, "input taken while a result waits")
`GCD4_ASSERT(a_error_zero, m_tvalid && m_tuser, m_tdata == '0, "count error with nonzero divisor")

endmodule

bind gcd_of_up_to_four gcd4_checker u_gcd4_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
